[hw/rtl/bed_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bed_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // one queue entry holds every result that one input beat causes
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       has0;
    logic       two;
    logic       done;
  } entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

`default_nettype wire

[hw/rtl/bed_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bed_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  input  wire logic            cfg_data,
  input  wire logic            s_tvalid,
  input  wire logic [7:0]      s_tdata,
  input  wire logic            s_tlast,
  output logic                 s_tready,
  input  wire logic            q_full,
  output logic                 q_push,
  output bed_pkg::entry_t      q_entry
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_OCT    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_DROP   = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] cnt;
  } emit_t;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_7   = 8'h37;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF_ = 8'h66;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] KEY_A  = 8'h61;
  localparam logic [7:0] KEY_B  = 8'h62;
  localparam logic [7:0] KEY_E  = 8'h65;
  localparam logic [7:0] KEY_UE = 8'h45;
  localparam logic [7:0] KEY_F  = 8'h66;
  localparam logic [7:0] KEY_N  = 8'h6E;
  localparam logic [7:0] KEY_R  = 8'h72;
  localparam logic [7:0] KEY_T  = 8'h74;
  localparam logic [7:0] KEY_V  = 8'h76;
  localparam logic [7:0] KEY_C  = 8'h63;
  localparam logic [7:0] KEY_X  = 8'h78;

  logic       enable;
  mode_t      mode;
  mode_t      mode_next;
  logic [8:0] digit_value;
  logic [8:0] digit_value_next;
  logic [1:0] digit_count;
  logic [1:0] digit_count_next;

  emit_t      em;
  logic       has0;
  logic       is_oct;
  logic [1:0] limit;
  logic       dig_ok;
  logic [3:0] dig;
  logic [8:0] acc;
  logic       accept;

  // at most two results per beat, extra ones are dropped
  function automatic emit_t push(emit_t e, logic [7:0] b);
    emit_t r;
    r = e;
    case (e.cnt)
      2'd0: begin
        r.b0  = b;
        r.cnt = 2'd1;
      end
      2'd1: begin
        r.b1  = b;
        r.cnt = 2'd2;
      end
      default: r = e;
    endcase
    return r;
  endfunction

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !q_full;
  assign is_oct   = (mode == MODE_OCT);
  assign limit    = is_oct ? 2'd3 : 2'd2;

  always_comb begin
    dig_ok = 1'b0;
    dig    = 4'd0;
    if (is_oct) begin
      if (s_tdata >= CH_0 && s_tdata <= CH_7) begin
        dig_ok = 1'b1;
        dig    = 4'(s_tdata - CH_0);
      end
    end else if (s_tdata >= CH_0 && s_tdata <= CH_9) begin
      dig_ok = 1'b1;
      dig    = 4'(s_tdata - CH_0);
    end else if (s_tdata >= CH_LA && s_tdata <= CH_LF_) begin
      dig_ok = 1'b1;
      dig    = 4'(s_tdata - CH_LA + 8'd10);
    end else if (s_tdata >= CH_UA && s_tdata <= CH_UF) begin
      dig_ok = 1'b1;
      dig    = 4'(s_tdata - CH_UA + 8'd10);
    end
    acc = is_oct ? {digit_value[5:0], 3'b000} + {5'd0, dig}
                 : {digit_value[4:0], 4'b0000} + {5'd0, dig};
  end

  always_comb begin
    em               = '0;
    has0             = 1'b1;
    mode_next        = mode;
    digit_value_next = digit_value;
    digit_count_next = digit_count;
    if (!enable) begin
      mode_next        = MODE_NORMAL;
      digit_value_next = '0;
      digit_count_next = '0;
      em               = push(em, s_tdata);
    end else begin
      case (mode)
        MODE_ESC: begin
          mode_next        = MODE_NORMAL;
          digit_value_next = '0;
          digit_count_next = '0;
          case (s_tdata)
            KEY_A:  em = push(em, CH_BEL);
            KEY_B:  em = push(em, CH_BS);
            KEY_E:  em = push(em, CH_ESC);
            KEY_UE: em = push(em, CH_ESC);
            KEY_F:  em = push(em, CH_FF);
            KEY_N:  em = push(em, CH_LF);
            KEY_R:  em = push(em, CH_CR);
            KEY_T:  em = push(em, CH_TAB);
            KEY_V:  em = push(em, CH_VT);
            CH_BSL: em = push(em, CH_BSL);
            KEY_C:  mode_next = MODE_DROP;
            CH_0:   mode_next = MODE_OCT;
            KEY_X:  mode_next = MODE_HEX;
            default: begin
              em = push(em, CH_BSL);
              em = push(em, s_tdata);
            end
          endcase
        end
        MODE_OCT, MODE_HEX: begin
          if (dig_ok && digit_count < limit) begin
            digit_value_next = acc;
            digit_count_next = digit_count + 2'd1;
            if ({1'b0, digit_count} + 3'd1 >= {1'b0, limit}) begin
              em               = push(em, acc[7:0]);
              mode_next        = MODE_NORMAL;
              digit_value_next = '0;
              digit_count_next = '0;
            end
          end else begin
            em               = push(em, digit_value[7:0]);
            mode_next        = MODE_NORMAL;
            digit_value_next = '0;
            digit_count_next = '0;
            if (s_tdata == CH_BSL) begin
              mode_next = MODE_ESC;
            end else begin
              em = push(em, s_tdata);
            end
          end
        end
        MODE_DROP: begin
          mode_next = MODE_DROP;
        end
        default: begin
          mode_next = MODE_NORMAL;
          if (s_tdata == CH_BSL) begin
            mode_next = MODE_ESC;
          end else begin
            em = push(em, s_tdata);
          end
        end
      endcase
    end
    if (s_tlast) begin
      if (mode_next == MODE_ESC) begin
        em = push(em, CH_BSL);
      end else if (mode_next == MODE_OCT || mode_next == MODE_HEX) begin
        em = push(em, digit_value_next[7:0]);
      end
      mode_next        = MODE_NORMAL;
      digit_value_next = '0;
      digit_count_next = '0;
      // nothing came out of this beat: send an empty end marker
      if (em.cnt == 2'd0) begin
        em.cnt = 2'd1;
        has0   = 1'b0;
      end
    end
  end

  assign q_push        = accept && (em.cnt != 2'd0);
  assign q_entry.b0    = em.b0;
  assign q_entry.b1    = em.b1;
  assign q_entry.has0  = has0;
  assign q_entry.two   = (em.cnt == 2'd2);
  assign q_entry.done  = s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      mode        <= MODE_NORMAL;
      digit_value <= '0;
      digit_count <= '0;
    end else begin
      if (cfg_valid) begin
        enable <= cfg_data;
      end
      if (accept) begin
        mode        <= mode_next;
        digit_value <= digit_value_next;
        digit_count <= digit_count_next;
      end
    end
  end

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_HEX) |-> (digit_count < 2'd2))
    else $error("hex digit count past limit");

endmodule

`default_nettype wire

[hw/rtl/bed_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bed_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bed_pkg::entry_t wr_entry,
  input  wire logic            pop,
  output bed_pkg::entry_t      rd_entry,
  output bed_pkg::qctl_t       ctl,
  output logic                 empty
);

  bed_pkg::entry_t              mem [bed_pkg::QDEPTH];
  logic [bed_pkg::QAW-1:0]      wr_ptr;
  logic [bed_pkg::QAW-1:0]      rd_ptr;
  logic [bed_pkg::QAW:0]        count;
  logic                         full;

  assign full     = (count == (bed_pkg::QAW+1)'(bed_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign rd_entry = mem[rd_ptr];
  assign ctl.push = push;
  assign ctl.full = full;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

[hw/rtl/bed_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bed_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bed_pkg::entry_t head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  logic phase;
  logic entry_last;
  logic beat;

  assign m_tvalid   = !empty;
  assign entry_last = phase || !head.two;
  assign beat       = m_tvalid && m_tready;
  assign pop        = beat && entry_last;
  assign m_tdata    = phase ? head.b1 : head.b0;
  assign m_tuser    = {entry_last, phase ? 1'b1 : head.has0};
  assign m_tlast    = entry_last && head.done;

  // phase marks the second beat of a two-result entry
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (beat) begin
      phase <= !entry_last;
    end
  end

  a_phase_two: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!empty && head.two))
    else $error("second beat without a two-result entry");

endmodule

`default_nettype wire

[hw/rtl/backslash_escape_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// results are pushed into the queue as their input beat is taken
// throughput: one input beat per cycle while the queue is not full; a
//   two-result entry takes two output beats; a four-entry queue absorbs that
// reset: synchronous active-high rst clears decode state, queue and enable (0)

module backslash_escape_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,      // escape_enable
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,       // in_byte
  input  wire logic       s_tlast,       // string_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,       // out_byte
  output logic [1:0]      m_tuser,       // [1] run_last, [0] has_byte
  output logic            m_tlast        // string_done
);

  bed_pkg::entry_t wr_entry;
  bed_pkg::entry_t head;
  bed_pkg::qctl_t  qctl;
  logic            push;
  logic            pop;
  logic            empty;

  assign cfg_ready = 1'b1;

  bed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tready  (s_tready),
    .q_full    (qctl.full),
    .q_push    (push),
    .q_entry   (wr_entry)
  );

  bed_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .ctl      (qctl),
    .empty    (empty)
  );

  bed_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    (qctl.push && !pop) |=> m_tvalid)
    else $error("queued results not offered");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_BSLASH,
    MODE_OCTAL,
    MODE_HEXDIG,
    MODE_DROP
  } dec_mode_t;

  typedef struct {
    logic [7:0] b;
    logic       fin;
  } feed_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_done;
  } result_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_X      = "x";
  localparam logic [7:0] CH_C      = "c";
  localparam logic [7:0] BEL       = 8'h07;
  localparam logic [7:0] BS        = 8'h08;
  localparam logic [7:0] ESC       = 8'h1B;
  localparam logic [7:0] FF        = 8'h0C;
  localparam logic [7:0] LF        = 8'h0A;
  localparam logic [7:0] CR        = 8'h0D;
  localparam logic [7:0] TAB       = 8'h09;
  localparam logic [7:0] VT        = 8'h0B;
  localparam int         HOLD_CYCLES = 60;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  backslash_escape_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder state mirrored on the bench side
  logic       esc_on = 1'b0;
  dec_mode_t  dec_mode = MODE_PLAIN;
  logic [8:0] digit_val = '0;
  logic [1:0] digit_cnt = '0;
  logic [7:0] stage_byte [2];
  logic       stage_has [2];
  int         stage_n;

  feed_t   string_q [$];
  result_t decoded_q [$];
  feed_t   nxt_beat;
  result_t want;

  int   beats_queued = 0;
  int   beats_taken = 0;
  int   beats_out = 0;
  int   strings_closed = 0;
  int   errors = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic quiet = 1'b0;

  task automatic report(input string what);
    errors++;
    if (errors <= 20) $display("%0t: mismatch: %s", $time, what);
  endtask

  function automatic void stage(input logic [7:0] v);
    if (stage_n < 2) begin
      stage_byte[stage_n] = v;
      stage_has[stage_n] = 1'b1;
      stage_n++;
    end
  endfunction

  function automatic void plain_byte(input logic [7:0] v);
    if (v == CH_BSLASH) dec_mode = MODE_BSLASH;
    else stage(v);
  endfunction

  function automatic void clear_digits();
    dec_mode = MODE_PLAIN;
    digit_val = '0;
    digit_cnt = '0;
  endfunction

  // works out the result beats for one accepted input beat
  function automatic void decode_beat(input logic [7:0] b, input logic fin);
    int      d;
    int      k;
    logic    oct;
    result_t r;
    stage_n = 0;
    if (!esc_on) begin
      clear_digits();
      stage(b);
    end else begin
      case (dec_mode)
        MODE_BSLASH: begin
          clear_digits();
          case (b)
            "a": stage(BEL);
            "b": stage(BS);
            "e", "E": stage(ESC);
            "f": stage(FF);
            "n": stage(LF);
            "r": stage(CR);
            "t": stage(TAB);
            "v": stage(VT);
            CH_BSLASH: stage(CH_BSLASH);
            CH_C: dec_mode = MODE_DROP;
            CH_ZERO: dec_mode = MODE_OCTAL;
            CH_X: dec_mode = MODE_HEXDIG;
            default: begin
              stage(CH_BSLASH);
              stage(b);
            end
          endcase
        end
        MODE_OCTAL, MODE_HEXDIG: begin
          oct = (dec_mode == MODE_OCTAL);
          d = -1;
          if (b >= "0" && b <= (oct ? "7" : "9")) d = b - "0";
          else if (!oct && b >= "a" && b <= "f") d = b - "a" + 10;
          else if (!oct && b >= "A" && b <= "F") d = b - "A" + 10;
          if (d >= 0) begin
            digit_val = 9'((digit_val << (oct ? 3 : 4)) + d);
            digit_cnt++;
            if (digit_cnt == (oct ? 2'd3 : 2'd2)) begin
              stage(digit_val[7:0]);
              clear_digits();
            end
          end else begin
            // pending value goes out first, then the byte as usual
            stage(digit_val[7:0]);
            clear_digits();
            plain_byte(b);
          end
        end
        MODE_DROP: ;
        default: begin
          dec_mode = MODE_PLAIN;
          plain_byte(b);
        end
      endcase
    end
    if (fin) begin
      if (dec_mode == MODE_BSLASH) stage(CH_BSLASH);
      else if (dec_mode == MODE_OCTAL || dec_mode == MODE_HEXDIG) stage(digit_val[7:0]);
      clear_digits();
      if (stage_n == 0) begin
        stage_byte[0] = 8'h00;
        stage_has[0] = 1'b0;
        stage_n = 1;
      end
    end
    for (k = 0; k < stage_n; k++) begin
      r.out_byte = stage_byte[k];
      r.has_byte = stage_has[k];
      r.run_last = (k == stage_n - 1);
      r.string_done = r.run_last && fin;
      decoded_q.push_back(r);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_beat(s_tdata, s_tlast);
        beats_taken++;
      end
      if (cfg_valid && cfg_ready) esc_on = cfg_data;
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (string_q.size() > 0) begin
          nxt_beat = string_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt_beat.b;
          s_tlast <= nxt_beat.fin;
          send_gap = quiet ? 0 : $urandom_range(0, 3);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        beats_out++;
        if (m_tlast) strings_closed++;
        if (decoded_q.size() == 0) begin
          report($sformatf("result beat %02h with nothing expected", m_tdata));
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata !== want.out_byte)
            report($sformatf("out_byte %02h, want %02h", m_tdata, want.out_byte));
          if (m_tuser[0] !== want.has_byte)
            report($sformatf("has_byte %b, want %b", m_tuser[0], want.has_byte));
          if (m_tuser[1] !== want.run_last)
            report($sformatf("run_last %b, want %b", m_tuser[1], want.run_last));
          if (m_tlast !== want.string_done)
            report($sformatf("string_done %b, want %b", m_tlast, want.string_done));
        end
        recv_gap = quiet ? 0 : $urandom_range(0, 3);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic feed(input logic [7:0] b, input logic fin);
    feed_t f;
    f.b = b;
    f.fin = fin;
    string_q.push_back(f);
    beats_queued++;
  endtask

  task automatic feed_text(input string t, input logic fin);
    int i;
    for (i = 0; i < t.len(); i++) feed(t[i], fin && (i == t.len() - 1));
  endtask

  // wait until every beat is taken and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (beats_taken != beats_queued || decoded_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed strings, some raw noise
  task automatic queue_string();
    logic [7:0] s [$];
    string      letters;
    string      hexchars;
    int         pieces;
    int         r;
    int         n;
    int         i;
    logic [7:0] c;
    letters = "abeEfnrtv\\";
    hexchars = "0123456789abcdefABCDEF";
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) feed(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else begin
      pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
      repeat (pieces) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_BSLASH);
          s.push_back(c);
        end else if (r < 55) begin
          s.push_back(CH_BSLASH);
          s.push_back(letters[$urandom_range(0, 9)]);
        end else if (r < 67) begin
          s.push_back(CH_BSLASH);
          s.push_back(CH_ZERO);
          n = $urandom_range(0, 3);
          repeat (n) s.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
        end else if (r < 79) begin
          s.push_back(CH_BSLASH);
          s.push_back(CH_X);
          n = $urandom_range(0, 2);
          repeat (n) s.push_back(hexchars[$urandom_range(0, 21)]);
        end else if (r < 82) begin
          s.push_back(CH_BSLASH);
          s.push_back(CH_C);
        end else if (r < 90) begin
          s.push_back(CH_BSLASH);
          s.push_back(8'($urandom_range(0, 255)));
        end else begin
          s.push_back(8'($urandom_range(0, 255)));
        end
      end
      for (i = 0; i < s.size(); i++) feed(s[i], i == s.size() - 1);
    end
  endtask

  initial begin : stimulus
    int chunk;
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // escapes off after reset: a backslash, the top byte and a zero byte pass through
    feed(CH_BSLASH, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'h00, 1'b1);
    drain();
    write_enable(1'b1);

    feed_text("\\n\\\\", 1'b1);
    feed_text("\\q\\0101", 1'b1);
    feed_text("\\x4g\\08\\x", 1'b1);
    feed_text("\\cz", 1'b1);
    feed_text("\\", 1'b1);
    feed_text("\\0777", 1'b1);

    for (chunk = 0; chunk < 5; chunk++) begin
      // leave an octal escape open across the register write while escapes are on
      feed_text("\\0", 1'b0);
      drain();
      quiet = (chunk == 1);
      write_enable(chunk != 2);
      if (chunk == 3) hold_req = 1'b1;
      target = beats_queued + 300;
      while (beats_queued < target) queue_string();
    end
    drain();

    $display("run covered %0d input beats, %0d result beats and %0d closed strings",
             beats_taken, beats_out, strings_closed);
    $display("escapes on and off, open escapes across writes, a %0d-cycle output stall",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
